[sv/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
// Holds the operation codes, status codes, sequencer states and the stored entry format.
// Used by spq_mem and sorted_priority_queue; has no dependencies of its own.
`default_nettype none

package spq_pkg;

	// Operation carried by each input word.
	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_REM = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	// Status returned with each output word.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_ERD,
		S_ECMP,
		S_DHEAD,
		S_SRD,
		S_SCMP,
		S_DRD,
		S_DWR,
		S_DONE
	} state_t;

	// One stored queue entry.
	typedef struct packed {
		logic signed [31:0] value;
		logic [7:0]         prio;
	} entry_t;

endpackage

`default_nettype wire

[sv/spq_mem.sv]
// Entry storage for the sorted priority queue: one write port, one registered read port.
// Depends on spq_pkg for the entry format.
`default_nettype none

module spq_mem import spq_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[sv/sorted_priority_queue.sv]
// Sorted priority queue kept in a memory in ascending priority order; needs spq_pkg, spq_mem.
// Inputs are taken only in idle. Clear, full enqueue and empty dequeue go straight to output.
// Enqueue moves entries of higher priority value back one place from the tail until an older
// entry of lower or equal value or the head ends the walk; dequeue moves later entries forward;
// remove scans for the value, then moves later entries forward. Each entry costs a registered
// read, then compare and write; output stalls hold the result. Reset empties the queue at once.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic signed [31:0] value,
	input  wire logic [7:0]         priority_req,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic signed [31:0]      out_value
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	state_t state_q, state_d;

	// Control registers.
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic signed [31:0] out_value_q;

	// Per-operation working registers.
	op_t               op_q;
	logic signed [31:0] val_q;
	logic [7:0]        pri_q;
	logic [CW-1:0]     idx_q;
	status_t           res_status_q;
	logic signed [31:0] res_value_q;

	// Memory interface.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;

	// Shared compare unit results.
	logic          prio_le;
	logic          val_eq;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] idx_inc;
	logic          out_take;
	logic          out_free;
	entry_t        new_entry;

	spq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign prio_le   = (rd_data.prio <= pri_q);
	assign val_eq    = (rd_data.value == val_q);
	assign idx_dec   = idx_q - ONE_C;
	assign idx_inc   = idx_q + ONE_C;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign new_entry = '{value: val_q, prio: pri_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (op_q)
					OP_ENQ: state_d = (count_q == CAP_C) ? S_DONE : S_ERD;
					OP_DEQ: state_d = (count_q == '0) ? S_DONE : S_DHEAD;
					OP_REM: state_d = S_SRD;
					default: state_d = S_DONE;
				endcase
			end
			S_ERD: state_d = (idx_q == '0) ? S_DONE : S_ECMP;
			S_ECMP: state_d = prio_le ? S_DONE : S_ERD;
			S_DHEAD: state_d = S_DRD;
			S_SRD: state_d = (idx_q < count_q) ? S_SCMP : S_DONE;
			S_SCMP: state_d = val_eq ? S_DRD : S_SRD;
			S_DRD: state_d = (idx_inc < count_q) ? S_DWR : S_DONE;
			S_DWR: state_d = S_DRD;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory requests and handshake outputs.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = new_entry;
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		case (state_q)
			S_DISP: begin
				// Dequeue fetches the head entry.
				rd_en   = (op_q == OP_DEQ);
				rd_addr = '0;
			end
			S_ERD: begin
				if (idx_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_dec[AW-1:0];
				end
			end
			S_ECMP: begin
				// Either the new entry lands here or the older entry moves back one place.
				wr_en   = 1'b1;
				wr_data = prio_le ? new_entry : rd_data;
			end
			S_SRD: begin
				rd_en = (idx_q < count_q);
			end
			S_DRD: begin
				rd_en   = (idx_inc < count_q);
				rd_addr = idx_inc[AW-1:0];
			end
			S_DWR: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_value = out_value_q;

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DISP && op_q == OP_CLR) begin
				count_q <= '0;
			end else if ((state_q == S_ERD && idx_q == '0) ||
			             (state_q == S_ECMP && prio_le)) begin
				count_q <= count_q + ONE_C;
			end else if (state_q == S_DRD && !(idx_inc < count_q)) begin
				count_q <= count_q - ONE_C;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
	end

	// Working registers of the operation in flight.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q  <= op_t'(op);
			val_q <= value;
			pri_q <= priority_req;
		end
		case (state_q)
			S_DISP: begin
				res_value_q <= '0;
				if (op_q == OP_ENQ) begin
					idx_q        <= count_q;
					res_status_q <= (count_q == CAP_C) ? ST_FULL : ST_OK;
				end else if (op_q == OP_DEQ) begin
					idx_q        <= '0;
					res_status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
				end else if (op_q == OP_REM) begin
					idx_q        <= '0;
					res_status_q <= ST_EMPTY;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_ECMP: begin
				if (!prio_le) begin
					idx_q <= idx_dec;
				end
			end
			S_DHEAD: begin
				res_value_q <= rd_data.value;
			end
			S_SCMP: begin
				if (val_eq) begin
					res_status_q <= ST_OK;
				end else begin
					idx_q <= idx_inc;
				end
			end
			S_DWR: begin
				idx_q <= idx_inc;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

`default_nettype wire
